[rtl/core/kfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfs_pkg
// Shared types and constants for the keyboard queue with strobe.
// ----------------------------------------------------------------------------
package kfs_pkg;

	typedef enum logic [1:0] {
		OP_KEYPRESS    = 2'd0,
		OP_READ_DATA   = 2'd1,
		OP_READ_STROBE = 2'd2,
		OP_TOGGLE_CAPS = 2'd3
	} kfs_op_t;

	localparam logic [2:0] SK_NONE   = 3'd0;
	localparam logic [2:0] SK_LEFT   = 3'd1;
	localparam logic [2:0] SK_UP     = 3'd2;
	localparam logic [2:0] SK_RIGHT  = 3'd3;
	localparam logic [2:0] SK_DOWN   = 3'd4;
	localparam logic [2:0] SK_DELETE = 3'd5;

	localparam logic CFG_BUFFER_ENABLE = 1'b0;
	localparam logic CFG_OLDER_MODEL   = 1'b1;

	localparam logic [7:0] STROBE_BIT = 8'h80;

	localparam logic [6:0] CH_LOWER_A  = 7'h61;
	localparam logic [6:0] CH_LOWER_Z  = 7'h7A;
	localparam logic [6:0] CH_BACKTICK = 7'h60;
	localparam logic [6:0] CH_BSLASH   = 7'h5C;
	localparam logic [6:0] CH_LBRACKET = 7'h5B;
	localparam logic [6:0] CH_RBRACKET = 7'h5D;
	localparam logic [6:0] CH_RETURN   = 7'h0D;
	localparam logic [6:0] CH_LINEFEED = 7'h0A;
	localparam logic [6:0] CTRL_BSLASH   = 7'd28;
	localparam logic [6:0] CTRL_LBRACKET = 7'd27;
	localparam logic [6:0] CTRL_RBRACKET = 7'd29;
	localparam logic [6:0] CASE_OFFSET   = 7'd32;

	typedef struct packed {
		logic older_model;
		logic caps_on;
	} kfs_mode_t;

	typedef struct packed {
		logic       drop;
		logic [6:0] code;
	} kfs_code_t;

	// Arrow and delete codes of both machine generations.
	function automatic logic [6:0] special_code(input logic [2:0] sk, input logic older);
		logic [6:0] c;
		begin
			unique case (sk)
				SK_LEFT:   c = 7'h08;
				SK_UP:     c = older ? 7'h0D : 7'h0B;
				SK_RIGHT:  c = 7'h15;
				SK_DOWN:   c = older ? 7'h2F : 7'h0A;
				SK_DELETE: c = older ? 7'h00 : 7'h7F;
				default:   c = 7'h00;
			endcase
			return c;
		end
	endfunction

endpackage
`default_nettype wire

[rtl/core/keyboard_fifo_with_strobe.sv]
`timescale 1ns / 1ps
`default_nettype none
// Keypresses and caps toggles are accepted back to back.
// In a data or strobe read the head entry comes from the registered key memory
// read in the cycle after the request, and read_byte is registered once the
// output is free. No new request is taken until read_byte has been registered.
// Reset empties the queue, turns caps lock on and enables the full queue;
// entries never written read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// keyboard_fifo_with_strobe
// Keyboard port with a ring queue of key codes, a data port and a strobe port.
// ----------------------------------------------------------------------------
module keyboard_fifo_with_strobe
	import kfs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic       cfg_data,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [1:0] operation,
	input  wire logic [6:0] key_char,
	input  wire logic [2:0] special_key,
	input  wire logic       ctrl_held,
	input  wire logic       key_held,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] read_byte
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t           state_q;
	logic             buffer_enable_q;
	logic             older_model_q;
	logic             caps_on_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] count_q;
	logic [6:0]       last_key_q;
	logic             strobe_rd_s1;
	logic             key_held_s1;
	logic             out_valid_q;
	logic [7:0]       read_byte_q;

	kfs_mode_t        mode;
	kfs_code_t        key_code;
	logic             accept;
	kfs_op_t          op;
	logic             full;
	logic             empty;
	logic             store_we;
	logic             store_re;
	logic [6:0]       head_code;
	logic             out_free;

	function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
			input logic buf_en);
		begin
			if (!buf_en || idx == IDX_W'(QUEUE_DEPTH - 1)) begin
				return '0;
			end
			return idx + 1'b1;
		end
	endfunction

	assign op       = kfs_op_t'(operation);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign mode.older_model = older_model_q;
	assign mode.caps_on     = caps_on_q;

	// With a single-entry queue any nonzero count is treated as full.
	assign full  = buffer_enable_q ? (count_q == CNT_W'(QUEUE_DEPTH)) : (count_q != '0);
	assign empty = (count_q == '0);

	kfs_keycode u_keycode (
		.key_char    (key_char),
		.special_key (special_key),
		.ctrl_held   (ctrl_held),
		.mode        (mode),
		.result      (key_code)
	);

	assign store_we = accept && (op == OP_KEYPRESS) && !key_code.drop;
	assign store_re = accept && (op == OP_READ_DATA || op == OP_READ_STROBE);

	kfs_store #(
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (store_we),
		.waddr  (wr_idx_q),
		.wdata  (key_code.code),
		.re     (store_re),
		.raddr  (rd_idx_q),
		.rdata  (head_code)
	);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_enable_q <= 1'b1;
			older_model_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BUFFER_ENABLE: buffer_enable_q <= cfg_data;
				CFG_OLDER_MODEL:   older_model_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			strobe_rd_s1 <= (op == OP_READ_STROBE);
			key_held_s1  <= key_held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			caps_on_q   <= 1'b1;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			count_q     <= '0;
			last_key_q  <= '0;
			out_valid_q <= 1'b0;
			read_byte_q <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_KEYPRESS: begin
								if (!key_code.drop) begin
									wr_idx_q <= advance(wr_idx_q, buffer_enable_q);
									if (full) begin
										// Overwrite the oldest entry.
										rd_idx_q <= advance(rd_idx_q, buffer_enable_q);
									end else begin
										count_q <= count_q + 1'b1;
									end
								end
							end
							OP_TOGGLE_CAPS: begin
								if (!older_model_q) begin
									caps_on_q <= !caps_on_q;
								end
							end
							default: begin
								state_q <= S_READ;
							end
						endcase
					end
				end
				S_READ: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (strobe_rd_s1) begin
							read_byte_q <= {key_held_s1, head_code};
							if (!empty) begin
								count_q  <= count_q - 1'b1;
								rd_idx_q <= advance(rd_idx_q, buffer_enable_q);
							end
						end else if (!empty) begin
							read_byte_q <= STROBE_BIT | {1'b0, head_code};
							last_key_q  <= head_code;
						end else begin
							read_byte_q <= {1'b0, last_key_q};
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_byte = read_byte_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(store_we && store_re))
		else $error("key memory read and write in the same cycle");

	a_read_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && out_free) |=> (out_valid && state_q == S_IDLE))
		else $error("read request did not produce a result");

	a_single_entry_index: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_KEYPRESS && !key_code.drop && !buffer_enable_q)
			|=> (wr_idx_q == '0))
		else $error("write index left zero with the queue disabled");

endmodule
`default_nettype wire

[rtl/core/kfs_keycode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfs_keycode
// Turns a decoded character or special key into the 7-bit machine key code.
// ----------------------------------------------------------------------------
module kfs_keycode
	import kfs_pkg::*;
(
	input  wire logic [6:0] key_char,
	input  wire logic [2:0] special_key,
	input  wire logic       ctrl_held,
	input  wire kfs_mode_t  mode,
	output kfs_code_t       result
);

	logic [6:0] ctrl_k;
	logic       is_lower;
	logic       ctrl_lower;

	assign ctrl_lower = (key_char >= CH_LOWER_A) && (key_char <= CH_LOWER_Z);

	always_comb begin
		ctrl_k = key_char;
		if (ctrl_held) begin
			if (ctrl_lower) begin
				ctrl_k = key_char - CH_BACKTICK;
			end else if (key_char == CH_BSLASH) begin
				ctrl_k = CTRL_BSLASH;
			end else if (key_char == CH_LBRACKET) begin
				ctrl_k = CTRL_LBRACKET;
			end else if (key_char == CH_RBRACKET) begin
				ctrl_k = CTRL_RBRACKET;
			end else if (key_char == CH_RETURN) begin
				ctrl_k = CH_LINEFEED;
			end
		end
	end

	assign is_lower = (ctrl_k >= CH_LOWER_A) && (ctrl_k <= CH_LOWER_Z);

	always_comb begin
		result.drop = (special_key > SK_DELETE);
		if (special_key != SK_NONE) begin
			result.code = special_code(special_key, mode.older_model);
		end else if (mode.older_model) begin
			// The older machine has no lowercase at all.
			result.code = (ctrl_k >= CH_BACKTICK) ? ctrl_k - CASE_OFFSET : ctrl_k;
		end else begin
			result.code = (mode.caps_on && is_lower) ? ctrl_k - CASE_OFFSET : ctrl_k;
		end
	end

endmodule
`default_nettype wire

[rtl/core/kfs_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfs_store
// Key code memory with one write and one registered read port. Entries that
// were never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module kfs_store
	import kfs_pkg::*;
#(
	parameter int DEPTH = 16,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire logic [6:0]       wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output      logic [6:0]       rdata
);

	logic [6:0]       mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [6:0]       rdata_s1;
	logic             rvalid_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_s1 <= valid_q[raddr];
			end
		end
	end

	assign rdata = rvalid_s1 ? rdata_s1 : 7'd0;

endmodule
`default_nettype wire

[verif/tb_keyboard_fifo_with_strobe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyboard_fifo_with_strobe
// Drives keypresses, caps toggles and data and strobe port reads into the
// keyboard queue, predicts every port read from its own copy of the queue
// and the mode registers, and checks each read byte in order. Sender gaps,
// receiver stalls and one long receiver hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_keyboard_fifo_with_strobe;
	import kfs_pkg::*;

	localparam int unsigned QDEPTH      = 16;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam logic [2:0]  SK_UNSUPPORTED = 3'd6;
	localparam logic [2:0]  SK_UNUSED      = 3'd7;

	typedef struct packed {
		kfs_op_t    op;
		logic [6:0] ch;
		logic [2:0] sk;
		logic       ctl;
		logic       held;
	} key_request_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = CFG_BUFFER_ENABLE;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] operation = OP_KEYPRESS;
	logic [6:0] key_char = 7'd0;
	logic [2:0] special_key = SK_NONE;
	logic       ctrl_held = 1'b0;
	logic       key_held = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] read_byte;

	keyboard_fifo_with_strobe #(.QUEUE_DEPTH(QDEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.key_char    (key_char),
		.special_key (special_key),
		.ctrl_held   (ctrl_held),
		.key_held    (key_held),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_byte   (read_byte)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted state of the key queue and the mode registers.
	logic [6:0]  key_mem [QDEPTH];
	int unsigned wr_ptr = 0;
	int unsigned rd_ptr = 0;
	int unsigned fill = 0;
	logic [6:0]  last_read = 7'd0;
	logic        caps_lock = 1'b1;
	logic        cfg_buf_en = 1'b1;
	logic        cfg_older = 1'b0;
	logic [7:0]  expected_bytes [$];

	int unsigned errors = 0;
	int unsigned burst_left = 0;
	bit          gaps_off = 1'b0;
	bit          in_busy = 1'b0;
	bit          hold_request = 1'b0;

	function automatic int unsigned queue_len();
		return cfg_buf_en ? QDEPTH : 1;
	endfunction

	function automatic int unsigned step_ptr(input int unsigned p);
		return (p + 1 >= queue_len()) ? 0 : p + 1;
	endfunction

	function automatic kfs_code_t code_for_key(input key_request_t r);
		kfs_code_t  c;
		logic [6:0] k;
		c.drop = 1'b0;
		c.code = 7'd0;
		k = r.ch;
		if (r.sk == SK_NONE) begin
			if (r.ctl) begin
				if (k >= CH_LOWER_A && k <= CH_LOWER_Z)
					k = k - CH_LOWER_A + 7'd1;
				else if (k == CH_BSLASH)
					k = CTRL_BSLASH;
				else if (k == CH_LBRACKET)
					k = CTRL_LBRACKET;
				else if (k == CH_RBRACKET)
					k = CTRL_RBRACKET;
				else if (k == CH_RETURN)
					k = CH_LINEFEED;
			end
			// The older machine folds everything from the backtick up into
			// the uppercase half; the newer one only touches letters.
			if (cfg_older)
				c.code = (k >= CH_BACKTICK) ? k - CASE_OFFSET : k;
			else if (caps_lock && k >= CH_LOWER_A && k <= CH_LOWER_Z)
				c.code = k - CASE_OFFSET;
			else
				c.code = k;
		end else begin
			case (r.sk)
				SK_LEFT:   c.code = 7'h08;
				SK_UP:     c.code = cfg_older ? 7'h0D : 7'h0B;
				SK_RIGHT:  c.code = 7'h15;
				SK_DOWN:   c.code = cfg_older ? 7'h2F : 7'h0A;
				SK_DELETE: c.code = cfg_older ? 7'h00 : 7'h7F;
				default:   c.drop = 1'b1;
			endcase
		end
		return c;
	endfunction

	function automatic void predict_request(input key_request_t r);
		kfs_code_t c;
		logic      full;
		case (r.op)
			OP_KEYPRESS: begin
				c = code_for_key(r);
				if (!c.drop) begin
					// A full queue overwrites its oldest entry.
					full = (fill >= queue_len());
					if (!full)
						fill++;
					key_mem[wr_ptr] = c.code;
					wr_ptr = step_ptr(wr_ptr);
					if (full)
						rd_ptr = step_ptr(rd_ptr);
				end
			end
			OP_READ_DATA: begin
				if (fill != 0) begin
					last_read = key_mem[rd_ptr];
					expected_bytes.push_back(STROBE_BIT | {1'b0, key_mem[rd_ptr]});
				end else begin
					expected_bytes.push_back({1'b0, last_read});
				end
			end
			OP_READ_STROBE: begin
				expected_bytes.push_back({r.held, key_mem[rd_ptr]});
				if (fill != 0) begin
					fill--;
					rd_ptr = step_ptr(rd_ptr);
				end
			end
			default: begin
				if (!cfg_older)
					caps_lock = !caps_lock;
			end
		endcase
	endfunction

	function automatic key_request_t make_request(input kfs_op_t op, input logic [6:0] ch,
			input logic [2:0] sk, input logic ctl, input logic held);
		key_request_t r;
		r.op = op;
		r.ch = ch;
		r.sk = sk;
		r.ctl = ctl;
		r.held = held;
		return r;
	endfunction

	function automatic logic [6:0] random_char();
		logic [6:0] picks [8];
		picks = '{CH_BSLASH, CH_LBRACKET, CH_RBRACKET, CH_RETURN, CH_BACKTICK,
			7'h7F, 7'h00, 7'h7B};
		case ($urandom_range(0, 5))
			0, 1:    return CH_LOWER_A + 7'($urandom_range(0, 25));
			2:       return 7'h41 + 7'($urandom_range(0, 25));
			3:       return picks[$urandom_range(0, 7)];
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	// Lowers valid if a request is still being presented.
	task automatic release_input();
		if (in_busy) begin
			in_valid <= 1'b0;
			in_busy = 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_request(input key_request_t r);
		int unsigned gap;
		if (!gaps_off) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
					: $urandom_range(0, 5);
				if (gap != 0) begin
					release_input();
					repeat (gap - 1) @(posedge clk);
				end
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		operation <= r.op;
		key_char <= r.ch;
		special_key <= r.sk;
		ctrl_held <= r.ctl;
		key_held <= r.held;
		in_busy = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_request(r);
	endtask

	// Waits out every pending read and any keypress still in flight.
	task automatic drain_results();
		release_input();
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic buf_en, input logic older);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_BUFFER_ENABLE;
		cfg_data <= buf_en;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_buf_en = buf_en;
		cfg_index <= CFG_OLDER_MODEL;
		cfg_data <= older;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_older = older;
		cfg_valid <= 1'b0;
	endtask

	// Receiver: a random duty pattern, redrawn each time its tick counter runs
	// out, plus a long hold-off on request.
	int unsigned hold_left = 0;
	int unsigned rx_tick = 0;
	int unsigned rx_phase = 0;
	int unsigned rx_period = 1;
	int unsigned rx_duty = 1;

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_tick == 0) begin
				rx_tick = 48;
				rx_period = $urandom_range(1, 6);
				rx_duty = $urandom_range(1, rx_period);
				if ($urandom_range(0, 3) == 0)
					rx_duty = rx_period;
			end
			rx_tick--;
			rx_phase = (rx_phase + 1) % rx_period;
			out_ready <= (rx_phase < rx_duty);
		end
	end

	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected read result: expected none, got %h",
					$time, read_byte);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (read_byte !== want) begin
					$display("%0t: read_byte mismatch: expected %h, got %h",
						$time, want, read_byte);
					errors++;
				end
			end
		end
	end

	task automatic test_empty_queue_reads();
		send_request(make_request(OP_READ_DATA, 7'h55, SK_NONE, 1'b0, 1'b1));
		send_request(make_request(OP_READ_STROBE, 7'h2A, SK_NONE, 1'b1, 1'b1));
	endtask

	task automatic test_key_coding();
		send_request(make_request(OP_KEYPRESS, CH_LOWER_A, SK_NONE, 1'b1, 1'b0));
		send_request(make_request(OP_KEYPRESS, CH_LOWER_Z, SK_NONE, 1'b1, 1'b0));
		send_request(make_request(OP_KEYPRESS, CH_BSLASH, SK_NONE, 1'b1, 1'b0));
		send_request(make_request(OP_KEYPRESS, CH_LBRACKET, SK_NONE, 1'b1, 1'b0));
		send_request(make_request(OP_KEYPRESS, CH_RBRACKET, SK_NONE, 1'b1, 1'b0));
		send_request(make_request(OP_KEYPRESS, CH_RETURN, SK_NONE, 1'b1, 1'b0));
		send_request(make_request(OP_KEYPRESS, 7'h71, SK_NONE, 1'b0, 1'b0));
		send_request(make_request(OP_TOGGLE_CAPS, 7'h00, SK_NONE, 1'b0, 1'b0));
		send_request(make_request(OP_KEYPRESS, 7'h71, SK_NONE, 1'b0, 1'b0));
		send_request(make_request(OP_KEYPRESS, 7'h7F, SK_NONE, 1'b0, 1'b1));
		send_request(make_request(OP_KEYPRESS, 7'h00, SK_LEFT, 1'b0, 1'b0));
		send_request(make_request(OP_KEYPRESS, 7'h00, SK_UP, 1'b1, 1'b0));
		send_request(make_request(OP_KEYPRESS, 7'h00, SK_RIGHT, 1'b0, 1'b0));
		send_request(make_request(OP_KEYPRESS, 7'h00, SK_DOWN, 1'b0, 1'b0));
		send_request(make_request(OP_KEYPRESS, 7'h00, SK_DELETE, 1'b0, 1'b0));
		send_request(make_request(OP_KEYPRESS, 7'h7F, SK_UNSUPPORTED, 1'b1, 1'b1));
		send_request(make_request(OP_KEYPRESS, 7'h00, SK_UNUSED, 1'b0, 1'b0));
		send_request(make_request(OP_READ_DATA, 7'h00, SK_NONE, 1'b0, 1'b0));
		send_request(make_request(OP_READ_STROBE, 7'h7F, SK_UNUSED, 1'b1, 1'b0));
		send_request(make_request(OP_READ_STROBE, 7'h00, SK_NONE, 1'b0, 1'b1));
		send_request(make_request(OP_READ_DATA, 7'h00, SK_NONE, 1'b0, 1'b0));
	endtask

	// The receiver stops for a long stretch while reads keep coming, so the
	// output path fills up and the block must stall its input.
	task automatic test_backpressure();
		int i;
		gaps_off = 1'b1;
		hold_request = 1'b1;
		for (i = 0; i < 30; i++) begin
			if (i % 3 == 0)
				send_request(make_request(OP_KEYPRESS, random_char(), SK_NONE,
					1'($urandom), 1'($urandom)));
			else
				send_request(make_request((i % 3 == 1) ? OP_READ_DATA : OP_READ_STROBE,
					random_char(), SK_NONE, 1'b0, 1'($urandom)));
		end
		gaps_off = 1'b0;
	endtask

	task automatic random_traffic(input int unsigned count, input int unsigned press_weight);
		key_request_t r;
		int unsigned  pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < press_weight) begin
				r.op = OP_KEYPRESS;
			end else begin
				pick = $urandom_range(0, 9);
				r.op = (pick < 4) ? OP_READ_DATA : (pick < 9) ? OP_READ_STROBE
					: OP_TOGGLE_CAPS;
			end
			r.ch = random_char();
			r.sk = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : SK_NONE;
			r.ctl = ($urandom_range(0, 2) == 0);
			r.held = 1'($urandom);
			send_request(r);
		end
	endtask

	// Mode changes leave queued entries in place, so the queue size also
	// changes while entries are waiting.
	task automatic test_mode_sweep();
		write_mode(1'b1, 1'b0);
		random_traffic(70, 60);
		write_mode(1'b0, 1'b0);
		random_traffic(60, 50);
		write_mode(1'b1, 1'b1);
		random_traffic(80, 65);
		write_mode(1'b0, 1'b1);
		random_traffic(50, 40);
		write_mode(1'b1, 1'b0);
		gaps_off = 1'b1;
		random_traffic(80, 70);
		gaps_off = 1'b0;
		write_mode(1'b1, 1'b1);
		random_traffic(40, 30);
		write_mode(1'b1, 1'b0);
		random_traffic(40, 30);
	endtask

	initial begin
		foreach (key_mem[i])
			key_mem[i] = 7'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue_reads();
		test_key_coding();
		test_backpressure();
		test_mode_sweep();
		release_input();
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("[keyboard_fifo_with_strobe] OK");
		else
			$display("[keyboard_fifo_with_strobe] ERROR");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("[keyboard_fifo_with_strobe] ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/core/kfs_pkg.sv
rtl/core/kfs_keycode.sv
rtl/core/kfs_store.sv
rtl/core/keyboard_fifo_with_strobe.sv
verif/tb_keyboard_fifo_with_strobe.sv
